// ===== src/time_segment_cache_index_assert.svh =====
// Assertion macros used by the checker of this block.
`ifndef TIME_SEGMENT_CACHE_INDEX_ASSERT_SVH
`define TIME_SEGMENT_CACHE_INDEX_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TSCI_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("time segment cache index check failed");

// The consequent must hold in the cycle after the antecedent.
`define TSCI_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("time segment cache index check failed");

`endif

// ===== src/tsci_pkg.sv =====
package tsci_pkg;

   localparam int MAX_SEGMENTS_DEF = 256;

   localparam int REQ_DATA_W = 72;
   localparam int RSP_DATA_W = 144;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_INDEX_W = 2;

   localparam logic [CSR_INDEX_W-1:0] CSR_ENABLE   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_BYTE_RATE = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_CAPACITY = 2'd2;

   localparam logic [23:0] BPS_RESET = 24'd176400;
   localparam logic [31:0] CAPACITY_RESET = 32'd268435456;
   localparam logic [9:0]  MS_PER_SECOND = 10'd1000;
   localparam logic [1:0]  EXTEND_SLACK_MS = 2'd2;

   localparam int NUM_W = 43;
   localparam int DIV_COUNT_W = 6;

   typedef enum logic {
      OP_WRITE = 1'b0,
      OP_FIND  = 1'b1
   } op_type;

   typedef struct packed {
      op_type      op;
      logic [31:0] position_ms;
      logic [23:0] byte_count;
      logic [15:0] tolerance_ms;
   } req_type;

   typedef struct packed {
      logic [31:0] start_ms;
      logic [31:0] length_ms;
      logic [31:0] size_bytes;
   } seg_type;

   typedef struct packed {
      logic        hit_found;
      logic [31:0] seg_start_ms;
      logic [31:0] seg_length_ms;
      logic [31:0] seg_bytes;
      logic [31:0] cached_bytes;
      logic [8:0]  stored_segments;
      logic        write_skipped;
   } rsp_type;

endpackage

// ===== src/tsci_front.sv =====
module tsci_front (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [tsci_pkg::REQ_DATA_W-1:0]  req_tdata,
   input  logic                             req_tuser,
   output logic                             item_valid,
   output tsci_pkg::req_type                item,
   input  logic                             item_pop
);
   import tsci_pkg::*;

   req_type    q_ff [2];
   logic       wr_ptr_ff;
   logic       rd_ptr_ff;
   logic [1:0] fill_ff;
   logic       push;
   logic       pop;
   req_type    incoming;

   always_comb begin
      incoming.op           = req_tuser ? OP_FIND : OP_WRITE;
      incoming.position_ms  = req_tdata[31:0];
      incoming.byte_count   = req_tdata[55:32];
      incoming.tolerance_ms = req_tdata[71:56];
   end

   assign req_tready = (fill_ff != 2'd2);
   assign push       = req_tvalid && req_tready;
   assign item_valid = (fill_ff != 2'd0);
   assign pop        = item_valid && item_pop;
   assign item       = q_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= incoming;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         if (push && !pop) begin
            fill_ff <= fill_ff + 2'd1;
         end else if (pop && !push) begin
            fill_ff <= fill_ff - 2'd1;
         end
      end
   end

endmodule

// ===== src/tsci_back.sv =====
module tsci_back #(
   parameter int MAX_SEGMENTS = tsci_pkg::MAX_SEGMENTS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              item_valid,
   input  tsci_pkg::req_type                 item,
   output logic                              item_pop,
   input  logic                              csr_we,
   input  logic [tsci_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [tsci_pkg::CSR_DATA_W-1:0]   csr_wdata,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output tsci_pkg::rsp_type                 rsp
);
   import tsci_pkg::*;

   localparam int AW = $clog2(MAX_SEGMENTS);
   localparam int CW = $clog2(MAX_SEGMENTS + 1);

   typedef enum logic [3:0] {
      S_IDLE, S_XRD, S_XCHK, S_APP, S_DRD, S_DDROP, S_MUL, S_DIV,
      S_WB, S_EVCHK, S_ERD, S_ESUB, S_FRD, S_FCHK, S_RESP
   } state_type;

   state_type         state_ff;
   logic              en_ff;
   logic [23:0]       bps_ff;
   logic [31:0]       cap_ff;
   logic [AW-1:0]     oldest_ff;
   logic [CW-1:0]     cnt_ff;
   logic [31:0]       total_ff;
   logic              flag_ff;
   req_type           item_ff;
   logic [AW-1:0]     addr_ff;
   logic [CW-1:0]     k_ff;
   logic [32:0]       acc_ff;
   logic              ext_ff;
   logic [31:0]       nsize_ff;
   logic              hit_ff;
   logic [NUM_W-1:0]  num_ff;
   logic [24:0]       rem_ff;
   logic [NUM_W-1:0]  quo_ff;
   logic [DIV_COUNT_W-1:0] step_ff;
   logic              rsp_valid_ff;
   rsp_type           rsp_ff;

   seg_type           mem [MAX_SEGMENTS];
   seg_type           rd_ff;
   logic              mem_we;
   logic [AW-1:0]     mem_waddr;
   seg_type           mem_wdata;

   logic [31:0]       src_bytes;
   logic [24:0]       rem_shift;
   logic              rem_ge;
   logic [31:0]       dur;
   logic [33:0]       ext_end;
   logic [32:0]       ext_sum;
   logic [32:0]       ext_lim;
   logic              extend_ok;
   logic [33:0]       find_end;
   logic [31:0]       cnt_wide;

   function automatic logic [AW-1:0] slot_at(input logic [AW-1:0] base,
                                             input logic [CW-1:0] k);
      logic [CW:0] s;
      s = (CW+1)'(base) + (CW+1)'(k);
      if (s >= (CW+1)'(MAX_SEGMENTS)) begin
         s = s - (CW+1)'(MAX_SEGMENTS);
      end
      return s[AW-1:0];
   endfunction

   always_comb begin
      src_bytes = ext_ff ? nsize_ff : 32'(item_ff.byte_count);
      rem_shift = {rem_ff[23:0], num_ff[NUM_W-1]};
      rem_ge    = (rem_shift >= {1'b0, bps_ff});
      if (quo_ff[NUM_W-1:32] != '0) begin
         dur = 32'hFFFF_FFFF;
      end else if (quo_ff[31:0] == 32'd0) begin
         dur = 32'd1;
      end else begin
         dur = quo_ff[31:0];
      end
      ext_end = 34'(rd_ff.start_ms) + 34'(rd_ff.length_ms) + 34'(EXTEND_SLACK_MS);
      ext_sum = 33'(rd_ff.size_bytes) + 33'(item_ff.byte_count);
      ext_lim = (item_ff.byte_count > bps_ff) ? 33'(item_ff.byte_count) : 33'(bps_ff);
      extend_ok = (item_ff.position_ms >= rd_ff.start_ms)
               && (34'(item_ff.position_ms) <= ext_end)
               && (ext_sum <= ext_lim);
      find_end = 34'(rd_ff.start_ms) + 34'(rd_ff.length_ms) + 34'(item_ff.tolerance_ms);
      cnt_wide = 32'(cnt_ff);
   end

   always_comb begin
      mem_we    = (state_ff == S_WB);
      mem_waddr = ext_ff ? addr_ff : slot_at(oldest_ff, cnt_ff);
      if (ext_ff) begin
         mem_wdata.start_ms   = rd_ff.start_ms;
         mem_wdata.length_ms  = (dur > rd_ff.length_ms) ? dur : rd_ff.length_ms;
         mem_wdata.size_bytes = nsize_ff;
      end else begin
         mem_wdata.start_ms   = item_ff.position_ms;
         mem_wdata.length_ms  = dur;
         mem_wdata.size_bytes = 32'(item_ff.byte_count);
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_ff <= mem[addr_ff];
   end

   assign item_pop  = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         en_ff        <= 1'b0;
         bps_ff       <= BPS_RESET;
         cap_ff       <= CAPACITY_RESET;
         oldest_ff    <= '0;
         cnt_ff       <= '0;
         total_ff     <= '0;
         flag_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         ext_ff       <= 1'b0;
         hit_ff       <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_ENABLE:    en_ff  <= csr_wdata[0];
               CSR_BYTE_RATE: bps_ff <= csr_wdata[23:0];
               CSR_CAPACITY:  cap_ff <= csr_wdata;
               default: ;
            endcase
         end
         if (rsp_valid_ff && rsp_ready && state_ff != S_RESP) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (item_valid) begin
                  item_ff <= item;
                  hit_ff  <= 1'b0;
                  ext_ff  <= 1'b0;
                  if (item.op == OP_FIND) begin
                     k_ff    <= cnt_ff;
                     addr_ff <= slot_at(oldest_ff, cnt_ff - CW'(1));
                     state_ff <= (!en_ff || cnt_ff == '0) ? S_RESP : S_FRD;
                  end else if (!en_ff || item.byte_count == '0 || bps_ff == '0) begin
                     state_ff <= S_RESP;
                  end else if (32'(item.byte_count) > cap_ff) begin
                     flag_ff  <= 1'b1;
                     state_ff <= S_RESP;
                  end else if (cnt_ff != '0) begin
                     addr_ff  <= slot_at(oldest_ff, cnt_ff - CW'(1));
                     state_ff <= S_XRD;
                  end else begin
                     state_ff <= S_APP;
                  end
               end
            end
            S_XRD: state_ff <= S_XCHK;
            S_XCHK: begin
               if (extend_ok) begin
                  nsize_ff <= ext_sum[31:0];
                  ext_ff   <= 1'b1;
                  state_ff <= S_MUL;
               end else begin
                  state_ff <= S_APP;
               end
            end
            S_APP: begin
               if (cnt_ff == CW'(MAX_SEGMENTS)) begin
                  addr_ff  <= oldest_ff;
                  state_ff <= S_DRD;
               end else begin
                  state_ff <= S_MUL;
               end
            end
            S_DRD: state_ff <= S_DDROP;
            S_DDROP: begin
               total_ff  <= total_ff - rd_ff.size_bytes;
               oldest_ff <= slot_at(oldest_ff, CW'(1));
               cnt_ff    <= cnt_ff - CW'(1);
               state_ff  <= S_APP;
            end
            S_MUL: begin
               num_ff   <= NUM_W'(src_bytes) * NUM_W'(MS_PER_SECOND)
                         + NUM_W'(bps_ff) - NUM_W'(1);
               rem_ff   <= '0;
               quo_ff   <= '0;
               step_ff  <= DIV_COUNT_W'(NUM_W - 1);
               state_ff <= S_DIV;
            end
            S_DIV: begin
               rem_ff  <= rem_ge ? rem_shift - {1'b0, bps_ff} : rem_shift;
               quo_ff  <= {quo_ff[NUM_W-2:0], rem_ge};
               num_ff  <= {num_ff[NUM_W-2:0], 1'b0};
               step_ff <= step_ff - DIV_COUNT_W'(1);
               if (step_ff == '0) begin
                  state_ff <= S_WB;
               end
            end
            S_WB: begin
               if (!ext_ff) begin
                  cnt_ff <= cnt_ff + CW'(1);
               end
               acc_ff   <= 33'(total_ff) + 33'(item_ff.byte_count);
               state_ff <= S_EVCHK;
            end
            S_EVCHK: begin
               if (acc_ff > 33'(cap_ff) && cnt_ff != '0) begin
                  addr_ff  <= oldest_ff;
                  state_ff <= S_ERD;
               end else begin
                  total_ff <= acc_ff[31:0];
                  state_ff <= S_RESP;
               end
            end
            S_ERD: state_ff <= S_ESUB;
            S_ESUB: begin
               acc_ff    <= acc_ff - 33'(rd_ff.size_bytes);
               oldest_ff <= slot_at(oldest_ff, CW'(1));
               cnt_ff    <= cnt_ff - CW'(1);
               state_ff  <= S_EVCHK;
            end
            S_FRD: state_ff <= S_FCHK;
            S_FCHK: begin
               if (rd_ff.start_ms <= item_ff.position_ms
                   && 34'(item_ff.position_ms) < find_end) begin
                  hit_ff   <= 1'b1;
                  state_ff <= S_RESP;
               end else if (find_end < 34'(item_ff.position_ms) || k_ff == CW'(1)) begin
                  state_ff <= S_RESP;
               end else begin
                  k_ff     <= k_ff - CW'(1);
                  addr_ff  <= (addr_ff == '0) ? AW'(MAX_SEGMENTS - 1) : addr_ff - AW'(1);
                  state_ff <= S_FRD;
               end
            end
            S_RESP: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_ff           <= 1'b1;
                  rsp_ff.hit_found       <= hit_ff;
                  rsp_ff.seg_start_ms    <= hit_ff ? rd_ff.start_ms : 32'd0;
                  rsp_ff.seg_length_ms   <= hit_ff ? rd_ff.length_ms : 32'd0;
                  rsp_ff.seg_bytes       <= hit_ff ? rd_ff.size_bytes : 32'd0;
                  rsp_ff.cached_bytes    <= total_ff;
                  rsp_ff.stored_segments <= cnt_wide[8:0];
                  rsp_ff.write_skipped   <= flag_ff;
                  state_ff               <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

// ===== src/time_segment_cache_index.sv =====
// Index of cached audio segments kept as an oldest-to-newest ring.
// Input words on req_: a write (tuser 0) adds a chunk of bytes at a start time,
// either growing the newest segment or appending a new one, then evicts the
// oldest segments while the byte total exceeds the capacity. A find (tuser 1)
// searches from newest to oldest for a segment covering the time.
// Every input word yields exactly one rsp_ word carrying the hit, the segment
// found and the totals after the item.
// Configuration must be written on csr_ only while the block is idle; the block itself does not enforce this.
// A write works out the segment duration in the 43-step radix-2 divider; each
// segment dropped from a full ring or evicted is read and removed in turn. A find
// reads and checks the segments visited one after another through the single
// read port of the segment memory. One item is worked on at a time; a two-word
// queue in front accepts new words meanwhile.
// Reset empties the ring and restores the register defaults; no clearing pass
// is needed. If rsp_tready is low the result is held in the output register,
// the next result waits behind it and the input queue fills, then req_tready
// drops.
module time_segment_cache_index #(
   parameter int MAX_SEGMENTS = tsci_pkg::MAX_SEGMENTS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // position_ms[31:0], byte_count[55:32], tolerance_ms[71:56]
   input  logic [tsci_pkg::REQ_DATA_W-1:0]   req_tdata,
   // action
   input  logic                              req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // seg_start_ms[31:0], seg_length_ms[63:32], seg_bytes[95:64],
   // cached_bytes[127:96], stored_segments[136:128], write_skipped[137]
   output logic [tsci_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // hit_found
   output logic                              rsp_tuser,
   input  logic                              csr_we,
   input  logic [tsci_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [tsci_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import tsci_pkg::*;

   logic    item_valid;
   req_type item;
   logic    item_pop;
   rsp_type rsp;

   tsci_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .item_valid (item_valid),
      .item       (item),
      .item_pop   (item_pop)
   );

   tsci_back #(
      .MAX_SEGMENTS (MAX_SEGMENTS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .item       (item),
      .item_pop   (item_pop),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp        (rsp)
   );

   assign rsp_tuser = rsp.hit_found;
   assign rsp_tdata = {6'd0, rsp.write_skipped, rsp.stored_segments, rsp.cached_bytes,
                       rsp.seg_bytes, rsp.seg_length_ms, rsp.seg_start_ms};

endmodule

// ===== src/tsci_checker.sv =====
`include "time_segment_cache_index_assert.svh"

module tsci_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [tsci_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input logic                             rsp_tuser
);

   `TSCI_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready,
                     rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))

   `TSCI_ASSERT_SAME(a_miss_zero, clock, reset, rsp_tvalid && !rsp_tuser,
                     rsp_tdata[95:0] == 96'd0)

   `TSCI_ASSERT_SAME(a_hit_length, clock, reset, rsp_tvalid && rsp_tuser,
                     rsp_tdata[63:32] != 32'd0 && rsp_tdata[95:64] != 32'd0)

   `TSCI_ASSERT_SAME(a_skip_sticky, clock, reset,
                     rsp_tvalid && $past(rsp_tvalid && rsp_tdata[137]),
                     rsp_tdata[137])

endmodule

bind time_segment_cache_index tsci_checker u_tsci_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
